// ===== sv/idfr_pkg.sv =====
package idfr_pkg;

    // Field widths on the stream ports.
    localparam int ID_W     = 10;
    localparam int CNT_W    = 11;
    localparam int MODE_W   = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    // Request kinds carried on the slave-side tuser.
    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_CHECK   = 2'd2
    } t_mode;

    // One result, packed from the lowest bit up: ok, id_out, is_free, live_count.
    typedef struct packed {
        logic [CNT_W-1:0] live_count;
        logic             is_free;
        logic [ID_W-1:0]  id_out;
        logic             ok;
    } t_result;

endpackage

// ===== sv/id_allocator_fifo_recycle_core.sv =====
// Channel   Direction  tdata (lowest bit up)                          tuser
// s_axis    in         id_in[9:0], zero pad to 16                      mode[1:0]
// m_axis    out        ok, id_out[9:0], is_free, live_count[10:0], pad  none
//
// One request is taken per clock while the output is not stalled; the accepting edge
// loads the input register, and its result moves to the output register once free.
// The free marks and the recycle queue are single-port-write memories with
// registered reads, bypassed on a same-cycle write, which keeps the rate at one.
// Synchronous active-low reset clears counters and valids; no clearing pass is
// needed since ids at or above the high-water count read as free.
// A stalled output holds the result, and one more request waits in the input
// register before s_axis_tready drops.
module id_allocator_fifo_recycle_core #(
    parameter int CAPACITY = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // id_in[9:0], zero pad above
    input  logic [idfr_pkg::S_DATA_W-1:0] s_axis_tdata,
    // mode[1:0]
    input  logic [idfr_pkg::MODE_W-1:0]   s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // ok, id_out[9:0], is_free, live_count[10:0], zero pad above
    output logic [idfr_pkg::M_DATA_W-1:0] m_axis_tdata
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IDW  = idfr_pkg::ID_W;
    localparam int CNTW = idfr_pkg::CNT_W;
    localparam int MDW  = idfr_pkg::M_DATA_W;
    localparam int KW   = (CW > IDW) ? CW : IDW;

    // Input register.
    logic                 r_p_vld;
    idfr_pkg::t_mode      r_p_mode;
    logic [IDW-1:0]       r_p_id;
    logic                 r_mark_rd;

    // Allocator state.
    logic [CW-1:0]        r_fresh, n_fresh;
    logic [IW-1:0]        r_head, n_head;
    logic [IW-1:0]        r_tail, n_tail;
    logic [CW-1:0]        r_fill, n_fill;
    logic [IW-1:0]        r_q_rd;

    // Memories.
    logic [IW-1:0]        r_queue [CAPACITY];
    logic                 r_mark  [CAPACITY];

    // Output register.
    logic                 r_m_vld;
    idfr_pkg::t_result    r_m_res;

    logic                 fire;
    logic                 s_acc;
    logic [CW-1:0]        live;
    logic [CW-1:0]        n_live;
    logic                 issued;
    logic                 can_alloc;
    logic                 q_nonempty;
    logic                 rel_ok;
    logic [IW-1:0]        got;
    logic [IW-1:0]        head_inc;
    logic [IW-1:0]        tail_inc;
    logic [IW-1:0]        rd_addr;
    logic                 q_we;
    logic [IW-1:0]        q_wdata;
    logic                 mk_we;
    logic [IW-1:0]        mk_addr;
    logic                 mk_data;
    idfr_pkg::t_result    res;

    // Handshake: the input register empties, or refills, whenever its request is processed.
    assign fire          = r_p_vld && (!r_m_vld || m_axis_tready);
    assign s_axis_tready = !r_p_vld || fire;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_vld;
    assign m_axis_tdata  = MDW'(r_m_res);

    // Conditions for the request in the input register.
    assign live       = r_fresh - r_fill;
    assign issued     = KW'(r_p_id) < KW'(r_fresh);
    assign can_alloc  = live < CW'(CAPACITY);
    assign q_nonempty = r_fill != '0;
    assign rel_ok     = issued && !r_mark_rd && (r_fill < CW'(CAPACITY));
    assign got        = q_nonempty ? r_q_rd : IW'(r_fresh);
    assign head_inc   = (r_head == IW'(CAPACITY - 1)) ? '0 : r_head + 1'b1;
    assign tail_inc   = (r_tail == IW'(CAPACITY - 1)) ? '0 : r_tail + 1'b1;
    assign rd_addr    = IW'(s_axis_tdata[IDW-1:0]);

    // Request processing and next state.
    always_comb begin
        n_fresh = r_fresh;
        n_head  = r_head;
        n_tail  = r_tail;
        n_fill  = r_fill;
        q_we    = 1'b0;
        q_wdata = IW'(r_p_id);
        mk_we   = 1'b0;
        mk_addr = IW'(r_p_id);
        mk_data = 1'b0;
        res     = '0;
        if (fire) begin
            unique case (r_p_mode)
                idfr_pkg::MODE_ALLOC: begin
                    if (can_alloc) begin
                        if (q_nonempty) begin
                            n_head = head_inc;
                            n_fill = r_fill - 1'b1;
                        end else begin
                            n_fresh = r_fresh + 1'b1;
                        end
                        mk_we      = 1'b1;
                        mk_addr    = got;
                        mk_data    = 1'b0;
                        res.ok     = 1'b1;
                        res.id_out = IDW'(got);
                    end
                end
                idfr_pkg::MODE_RELEASE: begin
                    if (rel_ok) begin
                        q_we    = 1'b1;
                        n_tail  = tail_inc;
                        n_fill  = r_fill + 1'b1;
                        mk_we   = 1'b1;
                        mk_data = 1'b1;
                        res.ok  = 1'b1;
                    end
                end
                idfr_pkg::MODE_CHECK: begin
                    res.ok      = 1'b1;
                    res.is_free = issued ? r_mark_rd : 1'b1;
                end
                default: begin
                    res = '0;
                end
            endcase
        end
        n_live         = n_fresh - n_fill;
        res.live_count = CNTW'(n_live);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_m_vld <= 1'b0;
            r_fresh <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_fill  <= '0;
        end else begin
            if (s_acc) begin
                r_p_vld <= 1'b1;
            end else if (fire) begin
                r_p_vld <= 1'b0;
            end
            if (fire) begin
                r_m_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_vld <= 1'b0;
            end
            r_fresh <= n_fresh;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_fill  <= n_fill;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_p_mode <= idfr_pkg::t_mode'(s_axis_tuser);
            r_p_id   <= s_axis_tdata[IDW-1:0];
        end
        if (fire) begin
            r_m_res <= res;
        end
    end

    // Recycle queue: write at the tail, keep the entry at the next head prefetched.
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_queue[r_tail] <= q_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_we && (r_tail == n_head)) begin
            r_q_rd <= q_wdata;
        end else begin
            r_q_rd <= r_queue[n_head];
        end
    end

    // Free marks: read the incoming id, forwarding a write to the same entry.
    always_ff @(posedge i_clk) begin
        if (mk_we) begin
            r_mark[mk_addr] <= mk_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            if (mk_we && (mk_addr == rd_addr)) begin
                r_mark_rd <= mk_data;
            end else begin
                r_mark_rd <= r_mark[rd_addr];
            end
        end
    end

endmodule

// ===== sv/idfr_checker.sv =====
module idfr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [idfr_pkg::M_DATA_W-1:0] m_axis_tdata
);

    idfr_pkg::t_result res;
    logic              s_acc;

    assign res   = idfr_pkg::t_result'(m_axis_tdata[$bits(idfr_pkg::t_result)-1:0]);
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // A newly offered result comes from a request accepted through the input register.
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_acc, 2))
        else $error("result without a request");

    // Requests are refused only while a result waits at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with the output free");

    // A handed-out id comes only from a successful allocate.
    a_id_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (res.id_out != '0) |-> res.ok && !res.is_free)
        else $error("id_out set on a failed or non-allocate result");

endmodule

bind id_allocator_fifo_recycle_core idfr_checker u_idfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
